// File: src/kwtq_pkg.sv
// ----------------------------------------------------------------------------
// kwtq_pkg
// Shared sizes, codes and constants of the keyed wake time queue.
// ----------------------------------------------------------------------------
package kwtq_pkg;

  // table size and derived index widths
  localparam int QUEUE_CAPACITY = 32;
  localparam int IDX_W = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
  localparam int CNT_W = $clog2(QUEUE_CAPACITY + 1);

  // field widths
  localparam int OBJ_W  = 16;
  localparam int TICK_W = 64;

  // due tick that means never wake
  localparam logic [TICK_W-1:0] NEVER_TICK = '1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

endpackage

// File: src/keyed_wake_time_queue.sv
// ----------------------------------------------------------------------------
// keyed_wake_time_queue
// Wake time table holding at most one pending tick per object id, with
// schedule/remove and advance-and-drain operations.
// ----------------------------------------------------------------------------
// The block takes one input word at a time and holds item_stall high until
// the last result word of that item has been taken. A schedule word walks
// every table slot once through the compare logic (one slot per cycle, set
// by the single read port of the slot memories) and gives one result word.
// An advance word makes the same walk to pick out due entries, then walks
// the table again for each woken object to find the lowest remaining id, and
// gives one result word per woken object (one ST_NONE word when nothing is
// due). Schedules with object id zero skip the walk and answer in the cycle
// after the input word is taken. After the last result word is taken the
// block returns to idle before it takes the next input word. While
// result_stall is high the block holds its current result word.
module keyed_wake_time_queue
  import kwtq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              kind,
  input  logic [OBJ_W-1:0]  object_id,
  input  logic [TICK_W-1:0] due_tick,
  input  logic [TICK_W-1:0] current_tick,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        status,
  output logic [OBJ_W-1:0]  woken_object,
  output logic              last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_RESULT
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          cnt;
  logic                      kind_r;
  logic [OBJ_W-1:0]          obj_r;
  logic [TICK_W-1:0]         tick_r;
  logic [QUEUE_CAPACITY-1:0] slot_valid;
  logic [QUEUE_CAPACITY-1:0] mark;
  logic                      found;
  logic [IDX_W-1:0]          free_idx;
  logic                      have_best;
  logic [OBJ_W-1:0]          best_obj;
  logic [IDX_W-1:0]          best_idx;
  status_t                   st_q;
  logic [OBJ_W-1:0]          woken_q;
  logic                      last_q;

  // slot memories, registered read
  logic [OBJ_W-1:0]  slot_object [QUEUE_CAPACITY];
  logic [TICK_W-1:0] slot_due    [QUEUE_CAPACITY];
  logic [OBJ_W-1:0]  rd_obj;
  logic [TICK_W-1:0] rd_due;

  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          p;
  logic                      proc;
  logic                      scan_end;
  logic                      hit;
  logic                      free_here;
  logic                      take_free;
  logic                      due_hit;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  logic                      take_best;
  logic [OBJ_W-1:0]          fin_obj;
  logic [IDX_W-1:0]          fin_idx;
  logic [QUEUE_CAPACITY-1:0] rest;

  // scan addressing: read slot cnt, process slot cnt-1 in the next cycle
  assign rd_addr  = IDX_W'(cnt);
  assign p        = IDX_W'(cnt - CNT_W'(1));
  assign proc     = (cnt != '0);
  assign scan_end = (cnt == CNT_W'(QUEUE_CAPACITY));

  // schedule side: match on object id, first slot free after removal
  assign hit       = slot_valid[p] && (rd_obj == obj_r);
  assign free_here = !slot_valid[p] || hit;
  assign take_free = proc && !found && free_here;
  assign wr_idx    = found ? free_idx : p;
  assign wr_en     = (state == S_SCAN) && !kind_r && scan_end &&
                     (found || take_free) && (tick_r != NEVER_TICK);

  // advance side: due check against the current tick
  assign due_hit = slot_valid[p] && (rd_due <= tick_r);

  // lowest marked object id search
  assign take_best = proc && mark[p] && (!have_best || (rd_obj < best_obj));
  assign fin_obj   = take_best ? rd_obj : best_obj;
  assign fin_idx   = take_best ? p : best_idx;

  always_comb begin
    rest = mark;
    rest[fin_idx] = 1'b0;
  end

  // slot memory write and read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_object[wr_idx] <= obj_r;
      slot_due[wr_idx]    <= tick_r;
    end
    rd_obj <= slot_object[rd_addr];
    rd_due <= slot_due[rd_addr];
  end

  // sequencer, table flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      mark       <= '0;
      cnt        <= '0;
      found      <= 1'b0;
      have_best  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            kind_r <= kind;
            obj_r  <= object_id;
            tick_r <= kind ? current_tick : due_tick;
            cnt    <= '0;
            found  <= 1'b0;
            if (!kind && (object_id == '0)) begin
              st_q    <= ST_OK;
              woken_q <= '0;
              last_q  <= 1'b1;
              state   <= S_RESULT;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (proc) begin
            if (kind_r) begin
              if (due_hit) begin
                slot_valid[p] <= 1'b0;
                mark[p]       <= 1'b1;
              end
            end else begin
              if (hit) begin
                slot_valid[p] <= 1'b0;
              end
              if (take_free) begin
                found    <= 1'b1;
                free_idx <= p;
              end
            end
          end
          if (scan_end) begin
            if (kind_r) begin
              if ((|mark) || due_hit) begin
                cnt       <= '0;
                have_best <= 1'b0;
                state     <= S_FIND;
              end else begin
                st_q    <= ST_NONE;
                woken_q <= '0;
                last_q  <= 1'b1;
                state   <= S_RESULT;
              end
            end else begin
              // new entry goes in after any removal of the old one
              if (wr_en) begin
                slot_valid[wr_idx] <= 1'b1;
              end
              st_q    <= ((tick_r == NEVER_TICK) || found || take_free) ? ST_OK : ST_FULL;
              woken_q <= '0;
              last_q  <= 1'b1;
              state   <= S_RESULT;
            end
          end
        end

        S_FIND: begin
          cnt <= cnt + CNT_W'(1);
          if (take_best) begin
            have_best <= 1'b1;
            best_obj  <= rd_obj;
            best_idx  <= p;
          end
          if (scan_end) begin
            st_q    <= ST_OK;
            woken_q <= fin_obj;
            last_q  <= (rest == '0);
            mark    <= rest;
            state   <= S_RESULT;
          end
        end

        S_RESULT: begin
          if (!result_stall) begin
            if (last_q) begin
              state <= S_IDLE;
            end else begin
              cnt       <= '0;
              have_best <= 1'b0;
              state     <= S_FIND;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ports
  assign item_stall   = (state != S_IDLE);
  assign result_valid = (state == S_RESULT);
  assign status       = st_q;
  assign woken_object = woken_q;
  assign last         = last_q;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed wake time queue. A behavioral copy of the
// wake table predicts the reply words of every accepted input word, and a
// checker compares each reply word field by field. The run covers directed
// corners, table overflow, random schedule/advance traffic, long result
// back-pressure and a full drain pause.
// ----------------------------------------------------------------------------
module tb;
  import kwtq_pkg::*;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_ADVANCE  = 1'b1
  } op_t;

  typedef struct {
    status_t          status;
    logic [OBJ_W-1:0] obj;
    logic             last;
  } wake_reply_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 2 * QUEUE_CAPACITY + 8;
  localparam int POOL_SIZE      = 40;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  logic              kind         = 1'b0;
  logic [OBJ_W-1:0]  object_id    = '0;
  logic [TICK_W-1:0] due_tick     = '0;
  logic [TICK_W-1:0] current_tick = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [1:0]        status;
  logic [OBJ_W-1:0]  woken_object;
  logic              last;

  // expected table contents and reply words still owed by the block
  logic [TICK_W-1:0] wake_table [bit [OBJ_W-1:0]];
  wake_reply_t       wake_replies [$];

  int fail_count    = 0;
  int sender_gap_pct = 0;
  int rx_stall_pct   = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  keyed_wake_time_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .object_id    (object_id),
    .due_tick     (due_tick),
    .current_tick (current_tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .woken_object (woken_object),
    .last         (last)
  );

  // clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // table behavior: work out the reply words of one accepted word
  function automatic void predict_table_op(op_t op, logic [OBJ_W-1:0] obj,
                                           logic [TICK_W-1:0] due,
                                           logic [TICK_W-1:0] now);
    bit [OBJ_W-1:0] woken [$];
    wake_reply_t    r;
    r.status = ST_OK;
    r.obj    = '0;
    r.last   = 1'b1;
    if (op == OP_SCHEDULE) begin
      // id zero leaves the table alone
      if (obj != '0) begin
        if (wake_table.exists(obj))
          wake_table.delete(obj);
        if (due != NEVER_TICK) begin
          if (wake_table.num() >= QUEUE_CAPACITY)
            r.status = ST_FULL;
          else
            wake_table[obj] = due;
        end
      end
      wake_replies = {wake_replies, r};
    end else begin
      // keys iterate in ascending id order
      foreach (wake_table[id])
        if (wake_table[id] <= now)
          woken = {woken, id};
      if (woken.size() == 0) begin
        r.status = ST_NONE;
        wake_replies = {wake_replies, r};
      end else begin
        foreach (woken[i]) begin
          wake_table.delete(woken[i]);
          r.obj  = woken[i];
          r.last = (i == woken.size() - 1);
          wake_replies = {wake_replies, r};
        end
      end
    end
  endfunction

  function automatic logic [TICK_W-1:0] rand_tick();
    return {$urandom, $urandom};
  endfunction

  // offer one word, starting and ending at a falling edge
  task automatic send_word(op_t op, logic [OBJ_W-1:0] obj, logic [TICK_W-1:0] due,
                           logic [TICK_W-1:0] now);
    while ($urandom_range(99) < sender_gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    kind         <= op;
    object_id    <= obj;
    due_tick     <= due;
    current_tick <= now;
    do @(posedge clk); while (item_stall !== 1'b0);
    predict_table_op(op, obj, due, now);
    @(negedge clk);
  endtask

  task automatic schedule_wake(logic [OBJ_W-1:0] obj, logic [TICK_W-1:0] due);
    send_word(OP_SCHEDULE, obj, due, rand_tick());
  endtask

  task automatic advance_to(logic [TICK_W-1:0] now);
    send_word(OP_ADVANCE, OBJ_W'($urandom), rand_tick(), now);
  endtask

  // idle mix change, with the sender parked
  task automatic set_idle_mix(int tx_pct, int rx_pct);
    item_valid <= 1'b0;
    @(posedge clk);
    sender_gap_pct = tx_pct;
    rx_stall_pct   = rx_pct;
    @(negedge clk);
  endtask

  task automatic test_directed_cases;
    advance_to('0);                               // empty table, nothing due
    schedule_wake('0, 64'd5);                     // id zero ignored
    schedule_wake(16'hFFFF, '0);
    schedule_wake(16'h0001, 64'hFFFF_FFFF_FFFF_FFFE);
    schedule_wake(16'h8000, 64'd100);
    schedule_wake(16'h8000, NEVER_TICK);          // remove only
    schedule_wake(16'h0007, 64'd50);
    schedule_wake(16'h0007, 64'd10);              // replaces earlier wake
    advance_to('0);                               // due equal to tick drains
    advance_to(64'd9);
    advance_to(64'd10);
    advance_to(64'd100);
    schedule_wake(16'h00FF, NEVER_TICK);          // remove of absent id
    schedule_wake(16'h5555, 64'h5555_5555_5555_5555);
    schedule_wake(16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    advance_to(64'hFFFF_FFFF_FFFF_FFFE);          // three, ascending
    advance_to(NEVER_TICK);
    schedule_wake('0, NEVER_TICK);
    schedule_wake(16'h1234, '0);
    schedule_wake(16'h0002, '0);
    advance_to(NEVER_TICK);
  endtask

  task automatic test_table_overflow;
    logic [OBJ_W-1:0] ids [$];
    bit               taken [bit [OBJ_W-1:0]];
    logic [OBJ_W-1:0] id;
    advance_to(NEVER_TICK);
    while (ids.size() < QUEUE_CAPACITY + 3) begin
      id = OBJ_W'($urandom_range(16'hFFFF, 1));
      if (!taken.exists(id)) begin
        taken[id] = 1'b1;
        ids = {ids, id};
      end
    end
    for (int i = 0; i < QUEUE_CAPACITY; i++)
      schedule_wake(ids[i], rand_tick() >> 1);
    schedule_wake(ids[QUEUE_CAPACITY], rand_tick() >> 1);     // table full
    schedule_wake(ids[3], rand_tick() >> 1);                  // own slot freed first
    schedule_wake(ids[QUEUE_CAPACITY + 1], NEVER_TICK);       // removal never rejected
    schedule_wake(ids[5], NEVER_TICK);
    schedule_wake(ids[QUEUE_CAPACITY + 1], rand_tick() >> 1);
    schedule_wake(ids[QUEUE_CAPACITY + 2], '0);               // full again
    advance_to(NEVER_TICK);                                   // every entry wakes
  endtask

  // mostly wakes around a moving tick over a small id pool, plus noise
  task automatic test_random_traffic(int n_words);
    logic [OBJ_W-1:0]  pool [POOL_SIZE];
    logic [TICK_W-1:0] base;
    int                pick;
    base = rand_tick() >> 1;
    foreach (pool[i])
      pool[i] = OBJ_W'($urandom_range(16'hFFFF, 1));
    repeat (n_words) begin
      pick = $urandom_range(99);
      if (pick < 58)
        schedule_wake(pool[$urandom_range(POOL_SIZE - 1)], base + $urandom_range(300));
      else if (pick < 64)
        schedule_wake(pool[$urandom_range(POOL_SIZE - 1)], NEVER_TICK);
      else if (pick < 67)
        schedule_wake('0, rand_tick());
      else if (pick < 71)
        schedule_wake(OBJ_W'($urandom), rand_tick());
      else if (pick < 92) begin
        advance_to(base + $urandom_range(300));
        base += $urandom_range(120);
      end else
        advance_to(rand_tick());
    end
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_result_backpressure;
    item_valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (5) begin
      schedule_wake(OBJ_W'($urandom_range(16'hFFFF, 1)), rand_tick() >> 1);
      advance_to(rand_tick());
    end
  endtask

  // sender waits for every reply word before going on
  task automatic test_drain_pause;
    repeat (4)
      schedule_wake(OBJ_W'($urandom_range(16'hFFFF, 1)), rand_tick());
    advance_to(rand_tick());
    item_valid <= 1'b0;
    while (wake_replies.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (3)
      schedule_wake(OBJ_W'($urandom_range(16'hFFFF, 1)), rand_tick());
    advance_to(NEVER_TICK);
  endtask

  // result side stall, with an optional long hold
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // compare each taken reply word with the oldest expectation
  always @(posedge clk) begin : check_replies
    wake_reply_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (wake_replies.size() == 0) begin
        $error("unexpected reply word: status %0d woken_object %0h last %0b",
               status, woken_object, last);
        fail_count++;
      end else begin
        want = wake_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
        if (woken_object !== want.obj) begin
          $error("woken_object: expected %0h, actual %0h", want.obj, woken_object);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idle_mix(9, 72);
    test_directed_cases;
    test_table_overflow;
    test_random_traffic(90);

    set_idle_mix(72, 9);
    test_random_traffic(90);
    test_result_backpressure;

    set_idle_mix(0, 0);
    test_random_traffic(90);
    test_drain_pause;

    // let the block settle, then report
    item_valid <= 1'b0;
    while (wake_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (wake_replies.size() != 0) begin
      $error("%0d reply words never arrived", wake_replies.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
